/* hw/rtl/ipasc_pkg.sv */
package ipasc_pkg;

    localparam logic [2:0] NET_IPV4     = 3'd0;
    localparam logic [2:0] NET_IPV6     = 3'd1;
    localparam logic [2:0] NET_TORV3    = 3'd2;
    localparam logic [2:0] NET_I2P      = 3'd3;
    localparam logic [2:0] NET_CJDNS    = 3'd4;
    localparam logic [2:0] NET_INTERNAL = 3'd5;

    localparam logic [2:0] REACH_NONE    = 3'd0;
    localparam logic [2:0] REACH_OTHER   = 3'd1;
    localparam logic [2:0] REACH_OVERLAY = 3'd2;
    localparam logic [2:0] REACH_CROSS   = 3'd3;
    localparam logic [2:0] REACH_SAME    = 3'd4;

    localparam int IN_DATA_W  = 256;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic [2:0]  network;
        logic [2:0]  source_network;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] addr_ext_hi;
        logic [63:0] addr_ext_lo;
    } t_addr_item;

    typedef struct packed {
        logic [2:0]  reachability;
        logic [15:0] group_key;
        logic        shared_cgnat;
        logic        unique_local;
        logic        link_local;
        logic        private_range;
        logic        multicast;
        logic        local_res;
        logic        routable;
        logic        valid_res;
    } t_scope_result;

    localparam int RES_W = $bits(t_scope_result);

    function automatic logic is_clear(input logic [2:0] net);
        return (net == NET_IPV4) || (net == NET_IPV6);
    endfunction

    function automatic logic is_overlay(input logic [2:0] net);
        return (net == NET_TORV3) || (net == NET_I2P) || (net == NET_CJDNS);
    endfunction

endpackage

/* hw/rtl/ip_address_scope_classifier.sv */
// Channel  | Direction | Payload
// s_axis   | in        | tdata: addr_hi, addr_lo, addr_ext_hi, addr_ext_lo;
//          |           | tuser: network, source_network
// m_axis   | out       | tdata: flags, group_key, reachability
//
// One transaction is accepted every cycle while m_axis does not stall; its result passes
// through the input register, then the result register, with the classification in
// between, and is shown on m_axis from the result register.
// Throughput is set by the two register stages, each of which refills in the
// cycle it empties. A stall on m_axis holds the result and backs up into s_axis
// once both stages are full. Reset is synchronous and empties both stages.
module ip_address_scope_classifier
    import ipasc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // addr_hi [63:0], addr_lo [127:64], addr_ext_hi [191:128], addr_ext_lo [255:192]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // network [2:0], source_network [5:3]
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // valid_res [0], routable [1], local_res [2], multicast [3], private_range [4],
    // link_local [5], unique_local [6], shared_cgnat [7], group_key [23:8],
    // reachability [26:24], zero [31:27]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic          r_in_valid;
    t_addr_item    r_item;
    logic          r_out_valid;
    t_scope_result r_res;
    t_scope_result n_res;
    logic          out_load;
    logic          in_load;

    assign out_load        = !r_out_valid || i_m_axis_tready;
    assign in_load         = !r_in_valid || out_load;
    assign o_s_axis_tready = in_load;

    ipasc_classify u_classify (
        .i_item (r_item),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_s_axis_tvalid) begin
            r_item.network        <= i_s_axis_tuser[2:0];
            r_item.source_network <= i_s_axis_tuser[5:3];
            r_item.addr_hi        <= i_s_axis_tdata[63:0];
            r_item.addr_lo        <= i_s_axis_tdata[127:64];
            r_item.addr_ext_hi    <= i_s_axis_tdata[191:128];
            r_item.addr_ext_lo    <= i_s_axis_tdata[255:192];
        end
        if (out_load && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, r_res};

endmodule

/* hw/rtl/ipasc_classify.sv */
module ipasc_classify
    import ipasc_pkg::*;
(
    input  t_addr_item    i_item,
    output t_scope_result o_res
);

    logic [7:0] b0, b1, b2, b3;
    logic       v4, v6, ovl;
    logic       valid, local_f, mcast, priv, ll, ula, cgn, routable, excl4, excl6;
    logic [2:0] reach;

    assign b0  = i_item.addr_hi[63:56];
    assign b1  = i_item.addr_hi[55:48];
    assign b2  = i_item.addr_hi[47:40];
    assign b3  = i_item.addr_hi[39:32];
    assign v4  = (i_item.network == NET_IPV4);
    assign v6  = (i_item.network == NET_IPV6);
    assign ovl = is_overlay(i_item.network);

    always_comb begin
        valid   = 1'b0;
        local_f = 1'b0;
        mcast   = 1'b0;
        priv    = 1'b0;
        ll      = 1'b0;
        ula     = 1'b0;
        cgn     = 1'b0;
        if (v4) begin
            valid   = (i_item.addr_hi[63:32] != 32'd0);
            mcast   = (b0[7:4] == 4'hE);
            priv    = (b0 == 8'd10) || (b0 == 8'd172 && b1[7:4] == 4'h1)
                      || (b0 == 8'd192 && b1 == 8'd168);
            ll      = (b0 == 8'd169) && (b1 == 8'd254);
            cgn     = (b0 == 8'd100) && (b1[7:6] == 2'b01);
            local_f = (b0 == 8'd127);
        end else if (v6) begin
            valid   = ((i_item.addr_hi | i_item.addr_lo) != 64'd0);
            mcast   = (b0 == 8'hFF);
            ll      = (b0 == 8'hFE) && (b1[7:6] == 2'b10);
            ula     = (b0[7:1] == 7'h7E);
            local_f = ((i_item.addr_hi == 64'd0) && (i_item.addr_lo == 64'd1))
                      || ((b0 == 8'hFE) && (b1[7:6] == 2'b10));
        end else if (ovl) begin
            valid   = ((i_item.addr_hi | i_item.addr_lo | i_item.addr_ext_hi
                        | i_item.addr_ext_lo) != 64'd0);
        end else if (i_item.network == NET_INTERNAL) begin
            valid   = 1'b1;
            local_f = 1'b1;
        end
    end

    assign excl4 = (b0 == 8'd0) || ll || priv || cgn
                   || (b0 == 8'd192 && b1 == 8'd0 && (b2 == 8'd0 || b2 == 8'd2))
                   || (b0 == 8'd198 && b1 == 8'd51 && b2 == 8'd100)
                   || (b0 == 8'd203 && b1 == 8'd0 && b2 == 8'd113)
                   || (b0 == 8'd198 && b1[7:1] == 7'd9)
                   || mcast || (b0 >= 8'd240);

    assign excl6 = ula || ll
                   || (b0 == 8'h20 && b1 == 8'h01 && b2 == 8'h0D && b3 == 8'hB8)
                   || (i_item.addr_hi == 64'h0100_0000_0000_0000)
                   || (b0 == 8'h20 && b1 == 8'h02)
                   || (b0 == 8'h20 && b1 == 8'h01 && b2 == 8'h00 && b3 == 8'h00)
                   || mcast;

    assign routable = valid && !local_f && ((v4 && !excl4) || (v6 && !excl6) || ovl);

    always_comb begin
        priority if (!routable) begin
            reach = REACH_NONE;
        end else if (i_item.source_network == i_item.network) begin
            reach = REACH_SAME;
        end else if (is_clear(i_item.source_network) && is_clear(i_item.network)) begin
            reach = REACH_CROSS;
        end else if ((is_clear(i_item.source_network) && ovl)
                     || (is_clear(i_item.network) && is_overlay(i_item.source_network))) begin
            reach = REACH_OVERLAY;
        end else begin
            reach = REACH_OTHER;
        end
    end

    always_comb begin
        o_res.valid_res     = valid;
        o_res.routable      = routable;
        o_res.local_res     = local_f;
        o_res.multicast     = mcast;
        o_res.private_range = priv;
        o_res.link_local    = ll;
        o_res.unique_local  = ula;
        o_res.shared_cgnat  = cgn;
        o_res.group_key     = (v4 || v6) ? {b0, b1} : {13'd0, i_item.network};
        o_res.reachability  = reach;
    end

endmodule

/* hw/rtl/ipasc_checker.sv */
module ipasc_checker
    import ipasc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result channel not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_routable_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> o_m_axis_tdata[0] && !o_m_axis_tdata[2])
        else $error("routable result is invalid or local");

    a_reach_matches_routable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[26:24] != REACH_NONE) == o_m_axis_tdata[1])
            && (o_m_axis_tdata[26:24] <= REACH_SAME))
        else $error("reachability disagrees with routable");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while result channel is empty");

endmodule

bind ip_address_scope_classifier ipasc_checker u_ipasc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* tb/sv/ip_address_scope_classifier_chk.sv */
`timescale 1ns / 100ps

module ip_address_scope_classifier_chk
    import ipasc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_scope_result expected_scopes[$];
    int            fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic t_scope_result predict_scope(input t_addr_item a);
        logic [7:0]    b0, b1, b2, b3;
        logic          v4, v6, ovl, src_clear, src_ovl, excluded;
        t_scope_result r;
        b0 = a.addr_hi[63:56];
        b1 = a.addr_hi[55:48];
        b2 = a.addr_hi[47:40];
        b3 = a.addr_hi[39:32];
        v4 = a.network == NET_IPV4;
        v6 = a.network == NET_IPV6;
        ovl = a.network == NET_TORV3 || a.network == NET_I2P || a.network == NET_CJDNS;
        src_clear = a.source_network == NET_IPV4 || a.source_network == NET_IPV6;
        src_ovl = a.source_network == NET_TORV3 || a.source_network == NET_I2P ||
                  a.source_network == NET_CJDNS;
        r = '0;

        if (v4) begin
            r.valid_res = |a.addr_hi[63:32];
        end else if (v6) begin
            r.valid_res = |{a.addr_hi, a.addr_lo};
        end else if (ovl) begin
            r.valid_res = |{a.addr_hi, a.addr_lo, a.addr_ext_hi, a.addr_ext_lo};
        end else if (a.network == NET_INTERNAL) begin
            r.valid_res = 1'b1;
        end

        if (v4) begin
            r.multicast = b0[7:4] == 4'hE;
            r.private_range = b0 == 8'd10 || (b0 == 8'd172 && b1[7:4] == 4'h1) ||
                              (b0 == 8'd192 && b1 == 8'd168);
            r.link_local = b0 == 8'd169 && b1 == 8'd254;
            r.shared_cgnat = b0 == 8'd100 && b1[7:6] == 2'b01;
            r.local_res = b0 == 8'd127;
        end else if (v6) begin
            r.multicast = b0 == 8'hFF;
            r.link_local = b0 == 8'hFE && b1[7:6] == 2'b10;
            r.unique_local = b0[7:1] == 7'b1111110;
            r.local_res = (a.addr_hi == 64'd0 && a.addr_lo == 64'd1) || r.link_local;
        end else if (a.network == NET_INTERNAL) begin
            r.local_res = 1'b1;
        end

        if (r.valid_res && !r.local_res) begin
            if (v4) begin
                excluded = b0 == 8'd0 || r.link_local || r.private_range || r.shared_cgnat ||
                           (b0 == 8'd192 && b1 == 8'd0 && (b2 == 8'd0 || b2 == 8'd2)) ||
                           (b0 == 8'd198 && b1 == 8'd51 && b2 == 8'd100) ||
                           (b0 == 8'd203 && b1 == 8'd0 && b2 == 8'd113) ||
                           (b0 == 8'd198 && b1[7:1] == 7'd9) ||
                           r.multicast || b0 >= 8'd240;
                r.routable = !excluded;
            end else if (v6) begin
                excluded = r.unique_local || r.link_local ||
                           {b0, b1, b2, b3} == 32'h2001_0DB8 ||
                           a.addr_hi == 64'h0100_0000_0000_0000 ||
                           {b0, b1} == 16'h2002 ||
                           {b0, b1, b2, b3} == 32'h2001_0000 ||
                           r.multicast;
                r.routable = !excluded;
            end else if (ovl) begin
                r.routable = 1'b1;
            end
        end

        r.group_key = (v4 || v6) ? {b0, b1} : {13'd0, a.network};

        if (!r.routable) begin
            r.reachability = REACH_NONE;
        end else if (a.source_network == a.network) begin
            r.reachability = REACH_SAME;
        end else if (src_clear && (v4 || v6)) begin
            r.reachability = REACH_CROSS;
        end else if ((src_clear && ovl) || ((v4 || v6) && src_ovl)) begin
            r.reachability = REACH_OVERLAY;
        end else begin
            r.reachability = REACH_OTHER;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_addr_item    item;
        t_scope_result want;
        t_scope_result got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                item.addr_hi = i_s_tdata[63:0];
                item.addr_lo = i_s_tdata[127:64];
                item.addr_ext_hi = i_s_tdata[191:128];
                item.addr_ext_lo = i_s_tdata[255:192];
                item.network = i_s_tuser[2:0];
                item.source_network = i_s_tuser[5:3];
                expected_scopes.push_back(predict_scope(item));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[RES_W-1:0];
                if (expected_scopes.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("unexpected result transaction: tdata=%h", i_m_tdata);
                    end
                    fail_total++;
                end else begin
                    want = expected_scopes.pop_front();
                    if (got !== want || i_m_tdata[OUT_DATA_W-1:RES_W] !== '0) begin
                        if (fail_total < 10) begin
                            $display({"result mismatch: expected valid=%0b routable=%0b ",
                                      "local=%0b mcast=%0b priv=%0b ll=%0b ula=%0b ",
                                      "cgnat=%0b key=%h reach=%0d"},
                                     want.valid_res, want.routable, want.local_res,
                                     want.multicast, want.private_range, want.link_local,
                                     want.unique_local, want.shared_cgnat, want.group_key,
                                     want.reachability);
                            $display({"                 actual   valid=%0b routable=%0b ",
                                      "local=%0b mcast=%0b priv=%0b ll=%0b ula=%0b ",
                                      "cgnat=%0b key=%h reach=%0d pad=%h"},
                                     got.valid_res, got.routable, got.local_res,
                                     got.multicast, got.private_range, got.link_local,
                                     got.unique_local, got.shared_cgnat, got.group_key,
                                     got.reachability, i_m_tdata[OUT_DATA_W-1:RES_W]);
                        end
                        fail_total++;
                    end
                end
            end
        end
        o_pending <= expected_scopes.size();
    end

endmodule

/* tb/sv/ip_address_scope_classifier_tb.sv */
`timescale 1ns / 100ps

module ip_address_scope_classifier_tb
    import ipasc_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 500;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [2:0] NET_UNKNOWN_LO = 3'd6;
    localparam logic [2:0] NET_UNKNOWN_HI = 3'd7;

    localparam logic [63:0] V4_PREFIX [20] = '{
        64'h0A00_0000_0000_0000, 64'h6440_0000_0000_0000, 64'h6400_0000_0000_0000,
        64'h7F00_0000_0000_0000, 64'hA9FE_0000_0000_0000, 64'hA900_0000_0000_0000,
        64'hAC10_0000_0000_0000, 64'hAC00_0000_0000_0000, 64'hC000_0000_0000_0000,
        64'hC000_0200_0000_0000, 64'hC0A8_0000_0000_0000, 64'hC000_0000_0000_0000,
        64'hC612_0000_0000_0000, 64'hC600_0000_0000_0000, 64'hC633_6400_0000_0000,
        64'hCB00_7100_0000_0000, 64'hCB00_0000_0000_0000, 64'hE000_0000_0000_0000,
        64'hF000_0000_0000_0000, 64'h0000_0000_0000_0000
    };
    localparam int V4_PLEN [20] = '{
        8, 10, 8, 8, 16, 8, 12, 8, 24, 24, 16, 8, 15, 8, 24, 24, 16, 4, 4, 8
    };
    localparam logic [63:0] V6_PREFIX [12] = '{
        64'hFE80_0000_0000_0000, 64'hFE00_0000_0000_0000, 64'hFC00_0000_0000_0000,
        64'hFF00_0000_0000_0000, 64'h2001_0DB8_0000_0000, 64'h2001_0000_0000_0000,
        64'h2001_0000_0000_0000, 64'h2002_0000_0000_0000, 64'h2000_0000_0000_0000,
        64'h0100_0000_0000_0000, 64'h0100_0000_0000_0000, 64'h0000_0000_0000_0000
    };
    localparam int V6_PLEN [12] = '{10, 8, 7, 8, 32, 16, 32, 16, 8, 64, 8, 32};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    ip_address_scope_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    ip_address_scope_classifier_chk scope_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] set_prefix(input logic [63:0] w, input logic [63:0] pfx,
                                               input int len);
        logic [63:0] mask;
        mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> len);
        return (w & ~mask) | (pfx & mask);
    endfunction

    function automatic t_addr_item make_address(input logic [2:0] net, input logic [63:0] hi,
                                                input logic [63:0] lo, input logic [63:0] ehi,
                                                input logic [63:0] elo, input logic [2:0] src);
        t_addr_item a;
        a.network = net;
        a.addr_hi = hi;
        a.addr_lo = lo;
        a.addr_ext_hi = ehi;
        a.addr_ext_lo = elo;
        a.source_network = src;
        return a;
    endfunction

    function automatic t_addr_item random_address();
        t_addr_item a;
        int         pick;
        a.addr_hi = rand_word();
        a.addr_lo = rand_word();
        a.addr_ext_hi = rand_word();
        a.addr_ext_lo = rand_word();
        pick = $urandom_range(99);
        if (pick < 35) begin
            a.network = NET_IPV4;
        end else if (pick < 70) begin
            a.network = NET_IPV6;
        end else if (pick < 85) begin
            a.network = 3'($urandom_range(NET_TORV3, NET_CJDNS));
        end else if (pick < 92) begin
            a.network = NET_INTERNAL;
        end else begin
            a.network = 3'($urandom_range(NET_UNKNOWN_LO, NET_UNKNOWN_HI));
        end
        if (a.network == NET_IPV4 && $urandom_range(3) != 0) begin
            pick = $urandom_range(19);
            a.addr_hi = set_prefix(a.addr_hi, V4_PREFIX[pick], V4_PLEN[pick]);
        end
        if (a.network == NET_IPV6 && $urandom_range(3) != 0) begin
            pick = $urandom_range(11);
            a.addr_hi = set_prefix(a.addr_hi, V6_PREFIX[pick], V6_PLEN[pick]);
        end
        if ($urandom_range(15) == 0) begin
            a.addr_hi = '0;
            a.addr_lo = $urandom_range(1) ? 64'd1 : 64'd0;
            if ($urandom_range(1)) begin
                a.addr_ext_hi = '0;
                a.addr_ext_lo = '0;
            end
        end else if ($urandom_range(15) == 0) begin
            a.addr_hi[63:32] = '0;
        end
        a.source_network = ($urandom_range(9) < 4) ? a.network : 3'($urandom_range(7));
        return a;
    endfunction

    task automatic send_address(input t_addr_item a);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata <= {a.addr_ext_lo, a.addr_ext_hi, a.addr_lo, a.addr_hi};
        s_tuser <= {a.source_network, a.network};
        do begin
            @(posedge i_clk);
        end while (!s_tready);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_address(make_address(NET_IPV4, '0, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, '1, '1, '1, '1, NET_IPV6));
        send_address(make_address(NET_IPV4, 64'h0808_0808_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'h0808_0808_1234_5678, '1, '0, '0, NET_TORV3));
        send_address(make_address(NET_IPV4, 64'h0101_0101_0000_0000, '0, '0, '0,
                                  NET_INTERNAL));
        send_address(make_address(NET_IPV4, 64'h0A01_0203_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'h6440_0001_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'h7F00_0001_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'hA9FE_0101_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'hAC10_0001_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'hC000_0201_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'hC633_6407_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'hCB00_7109_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV4, 64'hE000_0001_0000_0000, '0, '0, '0, NET_IPV4));
        send_address(make_address(NET_IPV6, '0, 64'd1, '0, '0, NET_IPV6));
        send_address(make_address(NET_IPV6, 64'hFE80_0000_0000_0000, 64'd1, '0, '0,
                                  NET_IPV6));
        send_address(make_address(NET_IPV6, 64'hFD00_0000_0000_0000, '0, '0, '0, NET_IPV6));
        send_address(make_address(NET_IPV6, 64'hFF02_0000_0000_0000, 64'd1, '0, '0,
                                  NET_IPV6));
        send_address(make_address(NET_IPV6, 64'h2001_0DB8_0000_0000, '0, '0, '0, NET_IPV6));
        send_address(make_address(NET_IPV6, 64'h0100_0000_0000_0000, 64'd5, '0, '0,
                                  NET_IPV6));
        send_address(make_address(NET_IPV6, 64'h2A00_1450_0000_0000, 64'd1, '0, '0,
                                  NET_IPV4));
        send_address(make_address(NET_TORV3, '0, '0, '0, 64'd1, NET_IPV6));
        send_address(make_address(NET_I2P, '0, '0, '0, '0, NET_I2P));
        send_address(make_address(NET_CJDNS, '1, '1, '1, '1, NET_CJDNS));
        send_address(make_address(NET_INTERNAL, '0, '0, '0, '0, NET_UNKNOWN_HI));
        send_address(make_address(NET_UNKNOWN_LO, '1, '1, '1, '1, NET_UNKNOWN_LO));
        send_address(make_address(NET_UNKNOWN_HI, '1, '1, '1, '1, NET_IPV4));

        // The receiver holds off for a long stretch while items keep coming,
        // so the pipeline fills and backs up into the input channel.
        hold_req = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default: begin
                    sender_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_address(random_address());
            end
        end
        @(negedge i_clk);
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ipasc_pkg.sv
hw/rtl/ipasc_classify.sv
hw/rtl/ip_address_scope_classifier.sv
hw/rtl/ipasc_checker.sv
tb/sv/ip_address_scope_classifier_chk.sv
tb/sv/ip_address_scope_classifier_tb.sv
